>>> rtl/core/hrhp_pkg.sv
package hrhp_pkg;

    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned POS_W      = 10;
    localparam int unsigned BASE_W     = 16;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned HALF_W     = 16;
    localparam int unsigned ACC_W      = 12;
    localparam int unsigned IDX_W      = 7;
    localparam int unsigned COUNT_W    = 8;

    localparam logic [CHAR_W-1:0] COLON_CHAR  = 8'd58;
    localparam logic [CHAR_W-1:0] DIGIT_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] DIGIT_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] ALPHA_BIAS  = 8'd55;
    localparam logic [BASE_W-1:0] BASE_RESET  = 16'h0800;

    // character numbers inside a record
    localparam logic [POS_W-1:0] POS_IDLE       = 10'd0;
    localparam logic [POS_W-1:0] POS_COUNT_HI   = 10'd1;
    localparam logic [POS_W-1:0] POS_COUNT_LO   = 10'd2;
    localparam logic [POS_W-1:0] POS_OFFSET_LO  = 10'd3;
    localparam logic [POS_W-1:0] POS_OFFSET_HI  = 10'd6;
    localparam logic [POS_W-1:0] POS_TYPE       = 10'd8;
    localparam logic [POS_W-1:0] POS_FIRST_DATA = 10'd9;
    localparam logic [POS_W-1:0] POS_MAX        = 10'd1023;

    // digit slot within a four-character group
    localparam logic [1:0] DIGIT_D0 = 2'd0;
    localparam logic [1:0] DIGIT_D1 = 2'd1;
    localparam logic [1:0] DIGIT_D2 = 2'd2;
    localparam logic [1:0] DIGIT_D3 = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] flash_address;
        logic [HALF_W-1:0] halfword_value;
        logic              record_last;
    } t_result;

    function automatic logic [3:0] hex_nibble(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] diff;
        begin
            if (ch >= DIGIT_ZERO && ch <= DIGIT_NINE) begin
                diff = ch - DIGIT_ZERO;
            end else begin
                diff = ch - ALPHA_BIAS;
            end
            hex_nibble = diff[3:0];
        end
    endfunction

endpackage

>>> rtl/core/hrhp_in_stage.sv
module hrhp_in_stage
    import hrhp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CHAR_W-1:0] i_record_char,
    input  logic              i_take,      // decoder consumes the held char
    output logic              o_held_valid,
    output logic [CHAR_W-1:0] o_held_char
);

    logic              r_valid;
    logic [CHAR_W-1:0] r_char;
    logic              n_valid;
    logic              load;

    assign o_stall = r_valid & ~i_take;
    assign load    = i_valid & ~o_stall;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_char <= i_record_char;
        end
    end

    assign o_held_valid = r_valid;
    assign o_held_char  = r_char;

endmodule

>>> rtl/core/hrhp_decoder.sv
module hrhp_decoder
    import hrhp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [CHAR_W-1:0] i_char,
    input  logic [BASE_W-1:0] i_base,
    output logic              o_emit,
    output t_result           o_result
);

    logic [POS_W-1:0]   r_pos,   n_pos;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [15:0]        r_offset, n_offset;
    logic               r_is_data, n_is_data;
    logic [ACC_W-1:0]   r_acc,   n_acc;
    logic [IDX_W-1:0]   r_idx,   n_idx;

    logic               is_colon;
    logic [3:0]         nib;
    logic [1:0]         digit;
    logic [IDX_W-1:0]   total;
    logic               in_data;
    logic [ADDR_W-1:0]  base_addr;

    assign is_colon  = (i_char == COLON_CHAR);
    assign nib       = hex_nibble(i_char);
    // first data char is number 9, so slot = (pos - 9) mod 4
    assign digit     = r_pos[1:0] - 2'd1;
    assign total     = r_count[COUNT_W-1:1];
    assign in_data   = (r_pos >= POS_FIRST_DATA) && (r_pos != POS_MAX) && r_is_data
                       && (r_idx < total);
    assign base_addr = {i_base, r_offset};

    assign o_emit = i_fire && !is_colon && in_data && (digit == DIGIT_D3);
    assign o_result.flash_address  = base_addr + {{(ADDR_W-IDX_W-1){1'b0}}, r_idx, 1'b0};
    assign o_result.halfword_value = {r_acc[3:0], nib, r_acc[11:8], r_acc[7:4]};
    assign o_result.record_last    = ({1'b0, r_idx} + 8'd1) == {1'b0, total};

    always_comb begin
        n_pos     = r_pos;
        n_count   = r_count;
        n_offset  = r_offset;
        n_is_data = r_is_data;
        n_acc     = r_acc;
        n_idx     = r_idx;
        if (i_fire) begin
            if (is_colon) begin
                n_pos     = POS_COUNT_HI;
                n_count   = '0;
                n_offset  = '0;
                n_is_data = 1'b0;
                n_acc     = '0;
                n_idx     = '0;
            end else if (r_pos != POS_IDLE) begin
                if (r_pos == POS_COUNT_HI) begin
                    n_count = {nib, 4'd0};
                end else if (r_pos == POS_COUNT_LO) begin
                    n_count = {r_count[7:4], nib};
                end else if (r_pos >= POS_OFFSET_LO && r_pos <= POS_OFFSET_HI) begin
                    n_offset = {r_offset[11:0], nib};
                end else if (r_pos == POS_TYPE) begin
                    n_is_data = (i_char == DIGIT_ZERO);
                end else if (in_data) begin
                    case (digit)
                        DIGIT_D0: n_acc = {nib, 8'd0};
                        DIGIT_D1: n_acc = r_acc | {4'd0, nib, 4'd0};
                        DIGIT_D2: n_acc = r_acc | {8'd0, nib};
                        default: begin
                            n_acc = '0;
                            n_idx = r_idx + 7'd1;
                        end
                    endcase
                end
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + 10'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_IDLE;
            r_count   <= '0;
            r_offset  <= '0;
            r_is_data <= 1'b0;
            r_acc     <= '0;
            r_idx     <= '0;
        end else begin
            r_pos     <= n_pos;
            r_count   <= n_count;
            r_offset  <= n_offset;
            r_is_data <= n_is_data;
            r_acc     <= n_acc;
            r_idx     <= n_idx;
        end
    end

endmodule

>>> rtl/core/hrhp_out_stage.sv
module hrhp_out_stage
    import hrhp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,     // slot can take a result this cycle
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_free = ~r_valid | ~i_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> rtl/core/hex_record_halfword_parser.sv
// Hex record halfword parser.
// Input channel: i_valid / o_stall with one ASCII char (i_record_char) per
//   transfer. A ':' starts a record; count, offset and type are decoded,
//   and each four-digit data group of a type '0' record gives one halfword.
// Output channel: o_valid / i_stall with o_flash_address, o_halfword_value
//   (bytes swapped) and o_record_last on the final halfword of the record.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_data, the upper 16
//   address bits. Always ready; a write is registered into the upper address bits.
// Data path: a char is registered on transfer, decoded when the decoder takes
//   it, and its halfword (if any) is registered in the result stage.
// Throughput: one char per cycle while the output is not stalled, set by
//   the single decode stage between the input register and the result register.
// Stall: a held result blocks the decoder only while i_stall is high; the
//   input register then fills and o_stall rises the same cycle.
// Reset (sync, active low): both stages empty, parser waits for ':',
//   upper address bits return to 16'h0800.
module hex_record_halfword_parser
    import hrhp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CHAR_W-1:0] i_record_char,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [ADDR_W-1:0] o_flash_address,
    output logic [HALF_W-1:0] o_halfword_value,
    output logic              o_record_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [BASE_W-1:0] i_cfg_data
);

    logic [BASE_W-1:0] r_base;
    logic              held_valid;
    logic [CHAR_W-1:0] held_char;
    logic              out_free;
    logic              take;
    logic              emit;
    t_result           dec_result;
    t_result           out_result;

    // config register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_base <= i_cfg_data;
        end
    end

    // decode only when a produced result would have a free slot
    assign take = held_valid & out_free;

    hrhp_in_stage u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_record_char (i_record_char),
        .i_take        (take),
        .o_held_valid  (held_valid),
        .o_held_char   (held_char)
    );

    hrhp_decoder u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (take),
        .i_char   (held_char),
        .i_base   (r_base),
        .o_emit   (emit),
        .o_result (dec_result)
    );

    hrhp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_result (dec_result),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result)
    );

    assign o_flash_address  = out_result.flash_address;
    assign o_halfword_value = out_result.halfword_value;
    assign o_record_last    = out_result.record_last;

endmodule

>>> dv/tb_hex_record_halfword_parser.sv
module tb_hex_record_halfword_parser;
    import hrhp_pkg::*;

    // Scoreboard: tracks the parser state char by char and queues the
    // halfwords each accepted char should produce, oldest first.
    class halfword_scoreboard;
        logic [BASE_W-1:0]  upper_half;
        logic [POS_W-1:0]   char_pos;
        logic [COUNT_W-1:0] byte_count;
        logic [15:0]        offset_low;
        bit                 is_data;
        logic [ACC_W-1:0]   nibble_acc;
        logic [IDX_W-1:0]   hw_index;
        t_result            pending_halfwords[$];
        int unsigned        mismatches;

        function new();
            upper_half = BASE_RESET;
            char_pos   = POS_IDLE;
            mismatches = 0;
            clear_record();
        endfunction

        function void clear_record();
            byte_count = '0;
            offset_low = '0;
            is_data    = 1'b0;
            nibble_acc = '0;
            hw_index   = '0;
        endfunction

        function void set_upper(input logic [BASE_W-1:0] value);
            upper_half = value;
        endfunction

        function int unsigned pending();
            return pending_halfwords.size();
        endfunction

        // Called on every accepted input transfer.
        function void note_char(input logic [CHAR_W-1:0] ch);
            logic [3:0]       nib;
            logic [POS_W-1:0] rel;
            logic [IDX_W-1:0] total;
            t_result          hw;
            if (ch == COLON_CHAR) begin
                clear_record();
                char_pos = POS_COUNT_HI;
                return;
            end
            if (char_pos == POS_IDLE) begin
                return;
            end
            // '0'..'9' keep their low nibble; anything else is ch - 55,
            // which on the low nibble is the same as adding 9
            nib = (ch >= DIGIT_ZERO && ch <= DIGIT_NINE) ? ch[3:0] : ch[3:0] + 4'd9;
            if (char_pos == POS_COUNT_HI) begin
                byte_count = {nib, 4'h0};
            end else if (char_pos == POS_COUNT_LO) begin
                byte_count[3:0] = nib;
            end else if (char_pos >= POS_OFFSET_LO && char_pos <= POS_OFFSET_HI) begin
                offset_low = {offset_low[11:0], nib};
            end else if (char_pos == POS_TYPE) begin
                is_data = (ch == DIGIT_ZERO);
            end else if (char_pos >= POS_FIRST_DATA && char_pos < POS_MAX && is_data) begin
                total = byte_count[COUNT_W-1:1];
                rel   = char_pos - POS_FIRST_DATA;
                if (hw_index < total) begin
                    case (rel[1:0])
                        DIGIT_D0: nibble_acc = {nib, 8'h00};
                        DIGIT_D1: nibble_acc[7:4] = nib;
                        DIGIT_D2: nibble_acc[3:0] = nib;
                        default: begin
                            hw.flash_address  = {upper_half, offset_low}
                                                + {24'd0, hw_index, 1'b0};
                            hw.halfword_value = {nibble_acc[3:0], nib,
                                                 nibble_acc[11:8], nibble_acc[7:4]};
                            hw.record_last    = (hw_index + 1'b1 == total);
                            pending_halfwords.push_back(hw);
                            hw_index   = hw_index + 1'b1;
                            nibble_acc = '0;
                        end
                    endcase
                end
            end
            if (char_pos < POS_MAX) begin
                char_pos = char_pos + 1'b1;
            end
        endfunction

        function void report(input string what);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%t: %s", $realtime, what);
            end
        endfunction

        // Called on every accepted output transfer.
        function void check_result(input t_result got);
            t_result want;
            if (pending_halfwords.size() == 0) begin
                report($sformatf("unexpected halfword addr=%h value=%h last=%b",
                                 got.flash_address, got.halfword_value, got.record_last));
                return;
            end
            want = pending_halfwords.pop_front();
            if (got.flash_address !== want.flash_address
                    || got.halfword_value !== want.halfword_value
                    || got.record_last !== want.record_last) begin
                report($sformatf("expected addr=%h value=%h last=%b, got addr=%h value=%h last=%b",
                                 want.flash_address, want.halfword_value, want.record_last,
                                 got.flash_address, got.halfword_value, got.record_last));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Block signals; every input has a known value from time zero.
    // ------------------------------------------------------------------
    logic                i_clk            = 1'b0;
    logic                i_rst_n          = 1'b0;
    logic                i_valid          = 1'b0;
    logic                o_stall;
    logic [CHAR_W-1:0]   i_record_char    = '0;
    logic                o_valid;
    logic                i_stall          = 1'b0;
    logic [ADDR_W-1:0]   o_flash_address;
    logic [HALF_W-1:0]   o_halfword_value;
    logic                o_record_last;
    logic                i_cfg_valid      = 1'b0;
    logic                o_cfg_ready;
    logic [BASE_W-1:0]   i_cfg_data       = '0;

    halfword_scoreboard  sb = new();

    // quiet: no gaps on either side for the current phase
    bit                  quiet      = 1'b0;
    int unsigned         chars_sent = 0;
    int                  stall_hold = 0;

    hex_record_halfword_parser dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_record_char    (i_record_char),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_flash_address  (o_flash_address),
        .o_halfword_value (o_halfword_value),
        .o_record_last    (o_record_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Gap length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    // ------------------------------------------------------------------
    // Result side: values are sampled as they stood just before the edge,
    // so a transfer is o_valid high with i_stall low at that edge. Stall
    // runs are drawn from the same gap mix as the input side.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result('{flash_address:  o_flash_address,
                              halfword_value: o_halfword_value,
                              record_last:    o_record_last});
        end
        if (stall_hold > 0) begin
            stall_hold--;
            i_stall <= 1'b1;
        end else begin
            stall_hold = pick_gap();
            i_stall <= (stall_hold > 0);
            if (stall_hold > 0) begin
                stall_hold--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side. The idle gap goes ahead of the char, so valid is only
    // lowered in the step of the previous transfer and raised again at a
    // later edge; back-to-back chars keep valid high throughout.
    // ------------------------------------------------------------------
    task automatic send_char(input logic [CHAR_W-1:0] ch);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_record_char <= ch;
        do @(posedge i_clk); while (o_stall);
        sb.note_char(ch);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    // Hex digit in random case; letters map back through ch - 55.
    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            return DIGIT_ZERO + n;
        end
        if ($urandom_range(0, 1)) begin
            return ALPHA_BIAS + n;
        end
        return ALPHA_BIAS + 8'd32 + n;
    endfunction

    // Data content: mostly hex digits, sometimes any byte except a colon.
    function automatic logic [CHAR_W-1:0] data_char();
        logic [CHAR_W-1:0] v;
        if ($urandom_range(0, 9) != 0) begin
            return hex_char(4'($urandom_range(0, 15)));
        end
        do v = 8'($urandom_range(0, 255)); while (v == COLON_CHAR);
        return v;
    endfunction

    // ':' count offset, a random char 7, the type char, the data chars
    // and a tail (checksum or whatever follows).
    task automatic send_record(input logic [7:0] count, input logic [15:0] offset,
                               input logic [CHAR_W-1:0] type_ch,
                               input int data_chars, input int tail_chars);
        send_char(COLON_CHAR);
        send_char(hex_char(count[7:4]));
        send_char(hex_char(count[3:0]));
        for (int i = 3; i >= 0; i--) begin
            send_char(hex_char(offset[4*i +: 4]));
        end
        send_char(hex_char(4'($urandom_range(0, 15))));
        send_char(type_ch);
        repeat (data_chars) send_char(data_char());
        repeat (tail_chars) send_char(hex_char(4'($urandom_range(0, 15))));
    endtask

    task automatic send_random_record();
        int                r;
        int                n;
        logic [7:0]        count;
        logic [15:0]       offset;
        logic [CHAR_W-1:0] other_type;
        r = $urandom_range(0, 99);
        n = $urandom_range(0, 99);
        // short records mostly, a long one of 41 to 255 bytes only now and then
        count  = (n < 90) ? 8'($urandom_range(0, 12))
               : (n < 98) ? 8'($urandom_range(13, 40)) : 8'($urandom_range(41, 255));
        offset = ($urandom_range(0, 7) == 0) ? 16'(16'hFFFF - $urandom_range(0, 8))
                                             : 16'($urandom);
        if (r < 70) begin
            send_record(count, offset, DIGIT_ZERO, 2 * count, 2);
        end else if (r < 80) begin
            do other_type = data_char(); while (other_type == DIGIT_ZERO);
            send_record(count, offset, other_type, 2 * count, 2);
        end else if (r < 90) begin
            // cut short; the next colon restarts the parser
            send_record(count, offset, DIGIT_ZERO, $urandom_range(0, 2 * count), 0);
        end else begin
            repeat ($urandom_range(1, 12)) send_char(8'($urandom_range(0, 255)));
        end
    endtask

    // Wait until every queued halfword has come out, then give the two
    // pipeline stages time to drain chars that produce nothing.
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Config write; the block is idle whenever this is called.
    task automatic write_upper(input logic [BASE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_upper(value);
    endtask

    initial begin
        int unsigned       rand_start;
        int                pick;
        logic [BASE_W-1:0] upper;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed, reset value of the upper address bits ---
        // chars before the first colon go nowhere
        send_char(8'h00);
        send_char(8'hFF);
        send_text("Z9");
        // two halfwords, second one flagged last
        send_text(":0400000012AB34CDEE");
        // odd count: the trailing byte is dropped
        send_text(":0310000000112233FF");
        // counts of zero and one emit nothing
        send_text(":00000000FF");
        send_text(":01123400AB11");
        // end-of-file and extended-address records are ignored
        send_text(":0200000001FFFF");
        send_text(":020000040800F2");
        // char 7 is ignored, only char 8 decides the type
        send_text(":02ABCD1099AAEE");
        // colon in the middle of the data restarts the record
        send_text(":04000000ABCD12");
        send_text(":0400200000ff7e3b");
        // non-hex chars, then extreme byte values as data digits
        send_text(":04000000G~pz");
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h80);
        send_char(8'h7F);

        // all-ones upper half: the address wraps past 2^32
        settle();
        write_upper(16'hFFFF);
        send_text(":04FFFE00112233445566");

        // largest count, cut short by the next colon
        settle();
        write_upper(16'h0000);
        send_record(8'hFF, 16'h0000, DIGIT_ZERO, 64, 0);
        send_text(":0200000012345A");

        // --- random phases, each with its own upper half ---
        rand_start = chars_sent;
        while (chars_sent - rand_start < 280) begin
            settle();
            pick = $urandom_range(0, 5);
            case (pick)
                0:       upper = 16'h0000;
                1:       upper = 16'hFFFF;
                2:       upper = BASE_RESET;
                default: upper = 16'($urandom);
            endcase
            write_upper(upper);
            quiet = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(3, 6)) send_random_record();
        end

        settle();
        if (sb.mismatches == 0) begin
            $display("hex_record_halfword_parser: match");
        end else begin
            $display("hex_record_halfword_parser: mismatch");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("hex_record_halfword_parser: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/hrhp_pkg.sv
rtl/core/hrhp_in_stage.sv
rtl/core/hrhp_decoder.sv
rtl/core/hrhp_out_stage.sv
rtl/core/hex_record_halfword_parser.sv
dv/tb_hex_record_halfword_parser.sv
